>>> src/sfr_pkg.sv
// Shared types, constants and the CRC byte update for the frame receiver.
// No dependencies; every other file of the block imports this package.
package sfr_pkg;

  localparam int unsigned LengthBits = 11;
  localparam logic [10:0] LenMask    = 11'((1 << LengthBits) - 1);

  localparam logic [7:0]  StartByte  = 8'h02;
  localparam logic [7:0]  EndByte    = 8'h03;
  localparam logic [15:0] CrcInit    = 16'hffff;
  localparam logic [15:0] CrcPoly    = 16'h1021;
  localparam logic [5:0]  OpLimitRst = 6'd32;

  typedef enum logic [2:0] {
    EvNone     = 3'd0,
    EvPayload  = 3'd1,
    EvHeader   = 3'd2,
    EvBadStart = 3'd3,
    EvBadOp    = 3'd4,
    EvCrcFail  = 3'd5,
    EvBadEnd   = 3'd6,
    EvFrameOk  = 3'd7
  } event_e;

  typedef struct packed {
    logic [7:0] data;
    logic       is_start;
    logic       is_end;
    logic       op_bad;
  } rx_class_t;

  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

>>> src/sfr_front.sv
// Input stage: registers each received byte and tags it (start, end, operation out of range).
// Depends on sfr_pkg.
module sfr_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           rx_byte_i,
  input  logic [5:0]           op_limit_i,
  output logic                 push_valid_o,
  input  logic                 push_ready_i,
  output sfr_pkg::rx_class_t   push_data_o
);
  import sfr_pkg::*;

  logic      valid_q, valid_d;
  rx_class_t item_q, item_d;
  logic      take;

  assign in_stall_o = valid_q && !push_ready_i;
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (take) begin
      valid_d       = 1'b1;
      item_d.data     = rx_byte_i;
      item_d.is_start = (rx_byte_i == StartByte);
      item_d.is_end   = (rx_byte_i == EndByte);
      item_d.op_bad   = ({1'b0, rx_byte_i[7:3]} >= op_limit_i);
    end else if (push_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign push_valid_o = valid_q;
  assign push_data_o  = item_q;

endmodule

>>> src/sfr_queue.sv
// Two-entry queue of tagged bytes between the input stage and the parser.
// Depends on sfr_pkg.
module sfr_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  output logic                 push_ready_o,
  input  sfr_pkg::rx_class_t   push_data_i,
  output logic                 pop_valid_o,
  input  logic                 pop_ready_i,
  output sfr_pkg::rx_class_t   pop_data_o
);
  import sfr_pkg::*;

  rx_class_t   slot_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> src/sfr_back.sv
// Frame parser: state machine, CRC check and registered event output.
// Depends on sfr_pkg.
module sfr_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 pop_valid_i,
  output logic                 pop_ready_o,
  input  sfr_pkg::rx_class_t   pop_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [2:0]           event_res_o,
  output logic [7:0]           payload_byte_o,
  output logic [10:0]          payload_index_o,
  output logic [4:0]           operation_o,
  output logic [10:0]          frame_length_o
);
  import sfr_pkg::*;

  typedef enum logic [2:0] {
    StIdle   = 3'd0,
    StHeadHi = 3'd1,
    StHeadLo = 3'd2,
    StData   = 3'd3,
    StCrcHi  = 3'd4,
    StCrcLo  = 3'd5,
    StEnd    = 3'd6
  } state_e;

  state_e      state_q, state_d;
  logic [7:0]  head_hi_q, head_hi_d;
  logic [4:0]  cur_op_q, cur_op_d;
  logic [10:0] exp_len_q, exp_len_d;
  logic [10:0] seen_q, seen_d;
  logic [15:0] crc_q, crc_d;
  logic        out_valid_q, out_valid_d;
  event_e      ev_q, ev_d;
  logic [7:0]  pbyte_q, pbyte_d;
  logic [10:0] pidx_q, pidx_d;
  logic [4:0]  op_q, op_d;
  logic [10:0] flen_q, flen_d;
  logic        step;
  logic [15:0] crc_next;
  logic [7:0]  b;

  assign pop_ready_o = !out_valid_q || !out_stall_i;
  assign step        = pop_valid_i && pop_ready_o;
  assign b           = pop_data_i.data;
  assign crc_next    = crc_feed(crc_q, b);

  always_comb begin
    state_d   = state_q;
    head_hi_d = head_hi_q;
    cur_op_d  = cur_op_q;
    exp_len_d = exp_len_q;
    seen_d    = seen_q;
    crc_d     = crc_q;
    ev_d      = EvNone;
    pbyte_d   = 8'h00;
    pidx_d    = 11'd0;
    unique case (state_q)
      StHeadHi: begin
        if (pop_data_i.op_bad) begin
          ev_d    = EvBadOp;
          state_d = StIdle;
        end else begin
          head_hi_d = b;
          state_d   = StHeadLo;
        end
      end
      StHeadLo: begin
        cur_op_d  = head_hi_q[7:3];
        exp_len_d = {head_hi_q[2:0], b} & LenMask;
        seen_d    = 11'd0;
        crc_d     = CrcInit;
        state_d   = (exp_len_d == 11'd0) ? StCrcHi : StData;
        ev_d      = EvHeader;
      end
      StData: begin
        ev_d    = EvPayload;
        pbyte_d = b;
        pidx_d  = seen_q;
        crc_d   = crc_next;
        seen_d  = seen_q + 11'd1;
        if (seen_d >= exp_len_q) begin
          state_d = StCrcHi;
        end
      end
      StCrcHi: begin
        crc_d   = crc_next;
        state_d = StCrcLo;
      end
      StCrcLo: begin
        crc_d = crc_next;
        if (crc_next != 16'h0000) begin
          ev_d    = EvCrcFail;
          state_d = StIdle;
        end else begin
          state_d = StEnd;
        end
      end
      StEnd: begin
        ev_d    = pop_data_i.is_end ? EvFrameOk : EvBadEnd;
        state_d = StIdle;
      end
      default: begin
        if (pop_data_i.is_start) begin
          state_d = StHeadHi;
        end else begin
          ev_d    = EvBadStart;
          state_d = StIdle;
        end
      end
    endcase
    op_d   = (ev_d == EvBadOp) ? b[7:3] : cur_op_d;
    flen_d = exp_len_d;

    out_valid_d = step ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      head_hi_q   <= 8'h00;
      cur_op_q    <= 5'd0;
      exp_len_q   <= 11'd0;
      seen_q      <= 11'd0;
      crc_q       <= CrcInit;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (step) begin
        state_q   <= state_d;
        head_hi_q <= head_hi_d;
        cur_op_q  <= cur_op_d;
        exp_len_q <= exp_len_d;
        seen_q    <= seen_d;
        crc_q     <= crc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      ev_q    <= ev_d;
      pbyte_q <= pbyte_d;
      pidx_q  <= pidx_d;
      op_q    <= op_d;
      flen_q  <= flen_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_res_o     = ev_q;
  assign payload_byte_o  = pbyte_q;
  assign payload_index_o = pidx_q;
  assign operation_o     = op_q;
  assign frame_length_o  = flen_q;

endmodule

>>> src/stx_etx_frame_receiver_crc16_core.sv
// Top level of the STX/ETX frame receiver with CRC-16/CCITT-FALSE check.
// Depends on sfr_pkg, sfr_front, sfr_queue and sfr_back.
//
// Takes one received byte per transfer and returns exactly one event per byte:
// none, payload byte with its index, header ok, bad start, bad operation, crc
// fail, bad end or frame ok; every error returns the parser to idle. Frames are
// 0x02, a 16-bit header (5-bit operation, length), payload, big-endian CRC over
// the payload, 0x03. While the output is not stalled, the block sustains one
// byte per clock cycle, set by the parser state register and the combinational
// CRC byte update in the back stage. A byte passes the input register and the
// queue before its event reaches the output register. The operation limit
// register resets to 32 and is written through the always-ready config channel.
module stx_etx_frame_receiver_crc16_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [5:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  event_res_o,
  output logic [7:0]  payload_byte_o,
  output logic [10:0] payload_index_o,
  output logic [4:0]  operation_o,
  output logic [10:0] frame_length_o
);
  import sfr_pkg::*;

  logic [5:0] op_limit_q;
  logic       push_valid, push_ready;
  rx_class_t  push_data;
  logic       pop_valid, pop_ready;
  rx_class_t  pop_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_limit_q <= OpLimitRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      op_limit_q <= cfg_data_i;
    end
  end

  sfr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .rx_byte_i    (rx_byte_i),
    .op_limit_i   (op_limit_q),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  sfr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  sfr_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pop_valid_i     (pop_valid),
    .pop_ready_o     (pop_ready),
    .pop_data_i      (pop_data),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .event_res_o     (event_res_o),
    .payload_byte_o  (payload_byte_o),
    .payload_index_o (payload_index_o),
    .operation_o     (operation_o),
    .frame_length_o  (frame_length_o)
  );

endmodule
